// File: rtl/core/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared constants, types and helpers for the comb reverb
// Sizes of the histories, gain formats, register map and saturation.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Block sizes (NUM_LINES and HISTORY_DEPTH are powers of two)
  localparam int NUM_LINES     = 4;
  localparam int HISTORY_DEPTH = 8192;
  localparam int SAMPLE_BITS   = 24;
  localparam int DELAY_REGS    = 4;

  localparam int HIST_AW    = $clog2(HISTORY_DEPTH);
  localparam int LINE_SHIFT = $clog2(NUM_LINES);
  localparam int LINE_W     = (NUM_LINES > 1) ? LINE_SHIFT : 1;
  localparam int COMB_AW    = LINE_W + HIST_AW;
  localparam int DLY_IW     = $clog2(DELAY_REGS);

  // Gain and register formats
  localparam int GAIN_FRAC  = 16;
  localparam int WET_W      = 17;
  localparam int FB_W       = 16;
  localparam int DELAY_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DELAY_STEP = 1000;

  localparam logic [WET_W-1:0] GAIN_UNITY = WET_W'(1 << GAIN_FRAC);
  localparam logic [WET_W-1:0] WET_RESET  = WET_W'(16384);
  localparam logic [FB_W-1:0]  FB_RESET   = FB_W'(32768);

  // Width of the value handed to the saturator
  localparam int SAT_IN_W = 48;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET      = 3'd0,
    REG_FEEDBACK = 3'd1,
    REG_DELAY0   = 3'd2,
    REG_DELAY1   = 3'd3,
    REG_DELAY2   = 3'd4,
    REG_DELAY3   = 3'd5
  } cfg_reg_t;

  // Reset delay of line register idx: 1000, 2000, ...
  function automatic logic [DELAY_W-1:0] delay_reset(input int unsigned idx);
    return DELAY_W'(DELAY_STEP * (idx + 1));
  endfunction

  // Clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-SAMPLE_BITS:0] top_bits;
    top_bits = v[SAT_IN_W-1:SAMPLE_BITS-1];
    if (top_bits == '0 || top_bits == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/core/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_if: request channels of the comb reverb
// Dry sample input, mixed sample output and register write channel.
// ----------------------------------------------------------------------------

// Dry sample channel
interface mcr_dry_if;
  import mcr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t dry_sample;
  modport source (output valid, output dry_sample, input ready);
  modport sink   (input valid, input dry_sample, output ready);
endinterface

// Mixed sample channel
interface mcr_mix_if;
  import mcr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t mixed_sample;
  modport source (output valid, output mixed_sample, input ready);
  modport sink   (input valid, input mixed_sample, output ready);
endinterface

// Register write channel
interface mcr_cfg_if;
  import mcr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mcr_ram.sv
// ----------------------------------------------------------------------------
// mcr_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/multi_comb_reverb.sv
// ----------------------------------------------------------------------------
// multi_comb_reverb: parallel feedback comb filter reverb
// Four comb lines over shared dry and comb histories, dry/wet mix output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed 24-bit dry sample per request.
//   out_ch : one saturated signed 24-bit mixed sample per input request.
//   cfg_ch : register writes (0 wet gain, 1 feedback gain, 2..5 line
//            delays), taken in any cycle outside reset; write only while
//            no sample is in flight. Other indexes are ignored.
// Timing:
//   A small microcode program steps through each sample: two steps per comb
//   line (history read, feedback multiply) plus four steps of overhead.
//   The result is loaded into the out_ch register at the last step, and the
//   next sample is taken only once the program is back at its first step,
//   as the single read port of each history RAM is visited once per line.
// Reset (rst_n low, synchronous) restores register defaults and empties all
//   histories at once: a write pointer and a wrap flag mark which slots hold
//   data, unwritten slots read as zero, so no clearing pass is needed.
// Stall: the result waits in the output register while one further sample
//   is taken and worked on; the program then holds at its last step until
//   out_ch takes the waiting result, so no more input is accepted meanwhile.
// ----------------------------------------------------------------------------
module multi_comb_reverb (
  input  logic      clk,
  input  logic      rst_n,
  mcr_dry_if.sink   in_ch,
  mcr_mix_if.source out_ch,
  mcr_cfg_if.sink   cfg_ch
);
  import mcr_pkg::*;

  // Datapath widths
  localparam int PROD_W = FB_W + 1 + SAMPLE_BITS;
  localparam int FBT_W  = PROD_W - GAIN_FRAC;
  localparam int CSUM_W = FBT_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + LINE_SHIFT;
  localparam int PD_W   = SAMPLE_BITS + WET_W + 1;
  localparam int PW_W   = SUM_W + WET_W + 1;
  localparam int MIX_W  = PW_W + 2;
  localparam int MIX_SH = GAIN_FRAC + LINE_SHIFT;
  localparam int MQ_W   = MIX_W - MIX_SH;

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1 << (GAIN_FRAC - 1));
  localparam logic signed [MIX_W-1:0]  MIX_HALF  = MIX_W'(1 << (MIX_SH - 1));

  // Program addresses
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_READ,
    ST_MULT,
    ST_LAST,
    ST_MIX,
    ST_EMIT
  } step_t;

  // Sequencing codes
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    logic  take;   // accept a dry sample
    logic  rd;     // read both histories for the current line
    logic  mul;    // feedback multiply on the read data
    logic  fin;    // finish the pending line: store and accumulate
    logic  mix;    // dry and wet mix products
    logic  emit;   // load the output register, commit the dry sample
    jmp_t  jmp;
    step_t target;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = '{take: 1'b0, rd: 1'b0, mul: 1'b0, fin: 1'b0, mix: 1'b0, emit: 1'b0,
          jmp: JMP_NEXT, target: ST_WAIT};
    case (s)
      ST_WAIT: begin
        c.take = 1'b1;
        c.jmp  = JMP_WAIT_IN;
      end
      ST_READ: begin
        c.rd  = 1'b1;
        c.fin = 1'b1;
      end
      ST_MULT: begin
        c.mul    = 1'b1;
        c.jmp    = JMP_LOOP;
        c.target = ST_READ;
      end
      ST_LAST: begin
        c.fin = 1'b1;
      end
      ST_MIX: begin
        c.mix = 1'b1;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.jmp    = JMP_WAIT_OUT;
        c.target = ST_WAIT;
      end
      default: begin
        c.jmp    = JMP_WAIT_OUT;
        c.target = ST_WAIT;
      end
    endcase
    return c;
  endfunction

  // Control state
  step_t               step_r, step_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;
  logic [LINE_W-1:0]   fin_line_r, fin_line_nxt;
  logic                fin_pend_r, fin_pend_nxt;
  logic [HIST_AW-1:0]  wp_r, wp_nxt;
  logic                full_r, full_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Configuration registers
  logic [WET_W-1:0]    wet_r, wet_nxt;
  logic [FB_W-1:0]     fb_r, fb_nxt;
  logic [DELAY_W-1:0]  delay_r [DELAY_REGS];
  logic [DELAY_W-1:0]  delay_nxt [DELAY_REGS];

  // Payload registers
  sample_t                   x_r, x_nxt;
  sample_t                   xd_r, xd_nxt;
  logic                      rd_ok_r, rd_ok_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [PD_W-1:0]    pdry_r, pdry_nxt;
  logic signed [PW_W-1:0]    pwet_r, pwet_nxt;
  sample_t                   out_data_r, out_data_nxt;

  // Combinational
  ctrl_t                     ctrl;
  logic                      in_acc, cfg_acc, fin_go, out_go, last_line;
  logic [DLY_IW-1:0]         dly_idx;
  logic [HIST_AW-1:0]        rd_slot;
  sample_t                   dry_q, comb_q, yd_m;
  logic signed [FB_W:0]      fb_s;
  logic signed [PROD_W-1:0]  prod_w, prod_rnd;
  logic signed [FBT_W-1:0]   fb_term;
  logic signed [CSUM_W-1:0]  comb_sum;
  sample_t                   y_fin;
  logic [WET_W-1:0]          wet_c, coef;
  logic signed [WET_W:0]     wet_s, coef_s;
  logic signed [PD_W-1:0]    pdry_w;
  logic signed [PW_W-1:0]    pwet_w;
  logic signed [MIX_W-1:0]   num;
  logic signed [MQ_W-1:0]    mix_q;
  sample_t                   mix_s;

  // Handshakes
  assign ctrl          = ucode(step_r);
  assign in_ch.ready   = ctrl.take & rst_n;
  assign cfg_ch.ready  = rst_n;
  assign in_acc        = in_ch.valid & in_ch.ready;
  assign cfg_acc       = cfg_ch.valid & cfg_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.mixed_sample = out_data_r;
  assign fin_go        = ctrl.fin & fin_pend_r;
  assign out_go        = ctrl.emit & (~out_valid_r | out_ch.ready);
  assign last_line     = (line_r == LINE_W'(NUM_LINES - 1));

  // Read slot of the current line; valid once written since reset
  assign dly_idx  = DLY_IW'(line_r % DELAY_REGS);
  assign rd_slot  = wp_r - HIST_AW'(delay_r[dly_idx]);

  // Feedback term: round half up, add delayed dry sample, saturate
  assign yd_m     = rd_ok_r ? comb_q : '0;
  assign fb_s     = {1'b0, fb_r};
  assign prod_w   = fb_s * yd_m;
  assign prod_rnd = prod_r + PROD_HALF;
  assign fb_term  = prod_rnd[PROD_W-1:GAIN_FRAC];
  assign comb_sum = CSUM_W'(fb_term) + CSUM_W'(xd_r);
  assign y_fin    = sat_sample(SAT_IN_W'(comb_sum));

  // Mix: wet gain clamped to one, dry weight is its complement
  assign wet_c   = (wet_r > GAIN_UNITY) ? GAIN_UNITY : wet_r;
  assign coef    = GAIN_UNITY - wet_c;
  assign wet_s   = {1'b0, wet_c};
  assign coef_s  = {1'b0, coef};
  assign pdry_w  = x_r * coef_s;
  assign pwet_w  = wet_s * sum_r;
  assign num     = (MIX_W'(pdry_r) <<< LINE_SHIFT) + MIX_W'(pwet_r) + MIX_HALF;
  assign mix_q   = num[MIX_W-1:MIX_SH];
  assign mix_s   = sat_sample(SAT_IN_W'(mix_q));

  // History memories
  mcr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(HISTORY_DEPTH)) u_dry_ram (
    .clk   (clk),
    .we    (out_go),
    .waddr (wp_r),
    .wdata (x_r),
    .re    (ctrl.rd),
    .raddr (rd_slot),
    .rdata (dry_q)
  );

  mcr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2 ** COMB_AW)) u_comb_ram (
    .clk   (clk),
    .we    (fin_go),
    .waddr ({fin_line_r, wp_r}),
    .wdata (y_fin),
    .re    (ctrl.rd),
    .raddr ({line_r, rd_slot}),
    .rdata (comb_q)
  );

  // Next state
  always_comb begin
    step_nxt      = step_r;
    line_nxt      = line_r;
    fin_line_nxt  = fin_line_r;
    fin_pend_nxt  = fin_pend_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    wet_nxt       = wet_r;
    fb_nxt        = fb_r;
    delay_nxt     = delay_r;
    x_nxt         = x_r;
    xd_nxt        = xd_r;
    rd_ok_nxt     = rd_ok_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    pdry_nxt      = pdry_r;
    pwet_nxt      = pwet_r;
    out_data_nxt  = out_data_r;

    // Register writes
    if (cfg_acc) begin
      if (cfg_ch.index == REG_WET) begin
        wet_nxt = cfg_ch.data[WET_W-1:0];
      end else if (cfg_ch.index == REG_FEEDBACK) begin
        fb_nxt = cfg_ch.data[FB_W-1:0];
      end else if (cfg_ch.index inside {[REG_DELAY0:REG_DELAY3]}) begin
        delay_nxt[DLY_IW'(cfg_ch.index - REG_DELAY0)] = cfg_ch.data[DELAY_W-1:0];
      end
    end

    // New sample
    if (ctrl.take && in_acc) begin
      x_nxt        = in_ch.dry_sample;
      sum_nxt      = '0;
      line_nxt     = '0;
      fin_pend_nxt = 1'b0;
    end

    // History read: slot holds data if written since reset
    if (ctrl.rd) begin
      rd_ok_nxt = full_r | (rd_slot < wp_r);
    end

    // Finish previous line
    if (fin_go) begin
      sum_nxt      = sum_r + SUM_W'(y_fin);
      fin_pend_nxt = 1'b0;
    end

    // Feedback multiply
    if (ctrl.mul) begin
      xd_nxt       = rd_ok_r ? dry_q : '0;
      prod_nxt     = prod_w;
      fin_line_nxt = line_r;
      fin_pend_nxt = 1'b1;
      if (!last_line) begin
        line_nxt = line_r + LINE_W'(1);
      end
    end

    // Mix products
    if (ctrl.mix) begin
      pdry_nxt = pdry_w;
      pwet_nxt = pwet_w;
    end

    // Result out, dry sample committed, write pointer advanced
    if (out_go) begin
      out_data_nxt  = mix_s;
      out_valid_nxt = 1'b1;
      wp_nxt        = wp_r + HIST_AW'(1);
      if (wp_r == HIST_AW'(HISTORY_DEPTH - 1)) begin
        full_nxt = 1'b1;
      end
    end

    // Sequencer
    case (ctrl.jmp)
      JMP_NEXT:     step_nxt = step_t'(step_r + 3'd1);
      JMP_WAIT_IN:  step_nxt = in_acc ? step_t'(step_r + 3'd1) : step_r;
      JMP_LOOP:     step_nxt = last_line ? step_t'(step_r + 3'd1) : ctrl.target;
      JMP_WAIT_OUT: step_nxt = out_go ? ctrl.target : step_r;
      default:      step_nxt = ST_WAIT;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_WAIT;
      line_r      <= '0;
      fin_line_r  <= '0;
      fin_pend_r  <= 1'b0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wet_r       <= WET_RESET;
      fb_r        <= FB_RESET;
      for (int i = 0; i < DELAY_REGS; i++) begin
        delay_r[i] <= delay_reset(i);
      end
    end else begin
      step_r      <= step_nxt;
      line_r      <= line_nxt;
      fin_line_r  <= fin_line_nxt;
      fin_pend_r  <= fin_pend_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      wet_r       <= wet_nxt;
      fb_r        <= fb_nxt;
      delay_r     <= delay_nxt;
    end
    x_r        <= x_nxt;
    xd_r       <= xd_nxt;
    rd_ok_r    <= rd_ok_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    pdry_r     <= pdry_nxt;
    pwet_r     <= pwet_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/core/mcr_checker.sv
// ----------------------------------------------------------------------------
// mcr_checker: port-level checks for the comb reverb
// One sample in flight at a time, results only from work done, clean reset.
// ----------------------------------------------------------------------------
module mcr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mcr_pkg::SAMPLE_BITS-1:0] out_mixed_sample
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result holds its value
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mixed_sample))
    else $error("stalled result changed or dropped");

  // Only one sample in flight: busy straight after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken while one is in flight");

  // A new result only comes from a sample being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind multi_comb_reverb mcr_checker u_mcr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_mixed_sample (out_ch.mixed_sample)
);
